/* src/fct_pkg.sv */
// Package for the FASTA codon translator: result type, constants and decode functions.
`default_nettype none
package fct_pkg;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_GT      = 8'h3E;
  localparam logic [7:0] CHAR_STOP    = 8'h2A;
  localparam logic [7:0] STOP_RESET   = 8'h58;

  localparam logic [7:0] CHAR_UP_A = 8'h41;
  localparam logic [7:0] CHAR_UP_T = 8'h54;
  localparam logic [7:0] CHAR_UP_U = 8'h55;
  localparam logic [7:0] CHAR_UP_G = 8'h47;
  localparam logic [7:0] CHAR_UP_C = 8'h43;
  localparam logic [7:0] CHAR_LO_A = 8'h61;
  localparam logic [7:0] CHAR_LO_T = 8'h74;
  localparam logic [7:0] CHAR_LO_U = 8'h75;
  localparam logic [7:0] CHAR_LO_G = 8'h67;
  localparam logic [7:0] CHAR_LO_C = 8'h63;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_T = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_C = 2'd3;

  // Codon index is first*16 + second*4 + third; the first letter sits in the top byte.
  localparam logic [64*8-1:0] CODON_STR = {
    "KNKNIIMIRSRSTTTT",
    "*Y*YLFLF*CWCSSSS",
    "EDEDVVVVGGGGAAAA",
    "QHQHLLLLRRRRPPPP"
  };

  typedef struct packed {
    logic [7:0] out_char;
    logic       is_residue;
    logic       last_of_run;
  } fct_res_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] code;
  } fct_base_t;

  function automatic logic [7:0] codon_aa(input logic [5:0] idx);
    logic [5:0] ri;
    ri = 6'd63 - idx;
    return CODON_STR[{ri, 3'b000} +: 8];
  endfunction

  function automatic fct_base_t base_decode(input logic [7:0] c);
    fct_base_t b;
    b.valid = 1'b1;
    b.code  = BASE_A;
    case (c)
      CHAR_UP_A, CHAR_LO_A: b.code = BASE_A;
      CHAR_UP_T, CHAR_LO_T, CHAR_UP_U, CHAR_LO_U: b.code = BASE_T;
      CHAR_UP_G, CHAR_LO_G: b.code = BASE_G;
      CHAR_UP_C, CHAR_LO_C: b.code = BASE_C;
      default: b.valid = 1'b0;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

/* src/fct_in_if.sv */
// Input channel interface: one byte of FASTA text per beat.
`default_nettype none
interface fct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink (input valid, input in_char, output ready);
endinterface
`default_nettype wire

/* src/fct_out_if.sv */
// Output channel interface: one emitted byte with its flags per beat.
`default_nettype none
interface fct_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       is_residue;
  logic       last_of_run;

  modport source (output valid, output out_char, output is_residue, output last_of_run,
                  input ready);
  modport sink (input valid, input out_char, input is_residue, input last_of_run,
                output ready);
endinterface
`default_nettype wire

/* src/fasta_codon_translator.sv */
// FASTA text to amino-acid translator, top level.
// Pipeline: a byte is registered in the input register on acceptance, and its results
// are then written into the output buffer, whose head entry drives the output beat.
// Throughput: one byte per cycle while the output buffer has room; a header start gives
// two results and is processed only when the two-entry output buffer can take both.
// Reset: asynchronous, active low; clears header and record state, base count and
// buffers, and sets the stop symbol to 'X'.
`default_nettype none
module fasta_codon_translator (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  fct_in_if.sink          in_i,
  fct_out_if.source       out_o
);

  logic [7:0] stop_q;
  logic       in_vld_q;
  logic [7:0] in_char_q;
  logic       in_header_q, in_header_d;
  logic       in_record_q, in_record_d;
  logic [1:0] held_q [2];
  logic [1:0] held_d [2];
  logic [1:0] base_count_q, base_count_d;

  fct_pkg::fct_res_t out_buf_q [2];
  fct_pkg::fct_res_t out_buf_d [2];
  logic [1:0] out_cnt_q, out_cnt_d;

  fct_pkg::fct_res_t res0, res1;
  logic [1:0] nres;
  fct_pkg::fct_base_t base;
  logic       pop, proc;
  logic [1:0] cnt_after;

  // Results and next state for the byte held in the input register.
  always_comb begin
    base         = fct_pkg::base_decode(in_char_q);
    nres         = 2'd0;
    res0         = '{out_char: in_char_q, is_residue: 1'b0, last_of_run: 1'b1};
    res1         = '{out_char: fct_pkg::CHAR_GT, is_residue: 1'b0, last_of_run: 1'b1};
    in_header_d  = in_header_q;
    in_record_d  = in_record_q;
    held_d       = held_q;
    base_count_d = base_count_q;
    if (in_header_q) begin
      nres = 2'd1;
      if (in_char_q == fct_pkg::CHAR_NEWLINE) begin
        in_header_d = 1'b0;
      end
    end else if (in_char_q == fct_pkg::CHAR_GT) begin
      nres         = 2'd2;
      res0         = '{out_char: fct_pkg::CHAR_NEWLINE, is_residue: 1'b0, last_of_run: 1'b0};
      in_header_d  = 1'b1;
      in_record_d  = 1'b1;
      base_count_d = 2'd0;
    end else if (in_record_q && base.valid) begin
      if (base_count_q < 2'd2) begin
        held_d[base_count_q[0]] = base.code;
        base_count_d = base_count_q + 2'd1;
      end else begin
        nres = 2'd1;
        res0.out_char = fct_pkg::codon_aa({held_q[0], held_q[1], base.code});
        if (res0.out_char == fct_pkg::CHAR_STOP) begin
          res0.out_char = stop_q;
        end
        res0.is_residue = 1'b1;
        base_count_d = 2'd0;
      end
    end
  end

  assign pop       = out_o.valid && out_o.ready;
  assign cnt_after = out_cnt_q - {1'b0, pop};
  assign proc      = in_vld_q && (({1'b0, nres} + {1'b0, cnt_after}) <= 3'd2);

  assign in_i.ready        = !in_vld_q || proc;
  assign out_o.valid       = out_cnt_q != 2'd0;
  assign out_o.out_char    = out_buf_q[0].out_char;
  assign out_o.is_residue  = out_buf_q[0].is_residue;
  assign out_o.last_of_run = out_buf_q[0].last_of_run;

  always_comb begin
    out_buf_d = out_buf_q;
    if (pop) begin
      out_buf_d[0] = out_buf_q[1];
    end
    if (proc) begin
      case (cnt_after)
        2'd0: begin
          out_buf_d[0] = res0;
          out_buf_d[1] = res1;
        end
        2'd1: begin
          out_buf_d[1] = res0;
        end
        default: begin
        end
      endcase
    end
    out_cnt_d = cnt_after + (proc ? nres : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q       <= fct_pkg::STOP_RESET;
      in_vld_q     <= 1'b0;
      in_header_q  <= 1'b0;
      in_record_q  <= 1'b0;
      base_count_q <= 2'd0;
      out_cnt_q    <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        stop_q <= cfg_wdata_i;
      end
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (proc) begin
        in_header_q  <= in_header_d;
        in_record_q  <= in_record_d;
        base_count_q <= base_count_d;
      end
      out_cnt_q <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_char_q <= in_i.in_char;
    end
    if (proc) begin
      held_q <= held_d;
    end
    out_buf_q <= out_buf_d;
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q <= 2'd2)
    else $error("output buffer count exceeds two entries");

  a_base_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_count_q != 2'd3)
    else $error("base count reached three");

  a_hdr_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && (nres == 2'd2) |=> in_header_q && in_record_q && (base_count_q == 2'd0)
                               && (out_cnt_q != 2'd0))
    else $error("header start did not enter header state");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !proc |=> in_vld_q && $stable(in_char_q))
    else $error("held input byte lost while stalled");

endmodule
`default_nettype wire
